@@ sv/sdi_pkg.sv @@
// Shared types and constants for the signed integer to decimal text converter.
`default_nettype none
package sdi_pkg;
   localparam int WORD_W        = 32;
   localparam int NUM_DIGITS    = 10;
   localparam int DIG_BITS      = 4 * NUM_DIGITS;
   localparam int CNT_W         = 4;
   localparam int CHAR_W        = 8;
   localparam int LIMIT_W       = 7;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = WORD_W / BITS_PER_STEP;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd12;
   localparam logic [CHAR_W-1:0]  CH_ZERO     = 8'h30;
   localparam logic [CHAR_W-1:0]  CH_MINUS    = 8'h2D;
   localparam logic [CHAR_W-1:0]  CH_NUL      = 8'h00;

   typedef struct packed {
      logic                neg;
      logic [DIG_BITS-1:0] digits;
      logic [CNT_W-1:0]    ndig;
      logic [CNT_W-1:0]    wid;
   } sdi_entry_type;
endpackage
`default_nettype wire

@@ sv/sdi_front.sv @@
// Front end: takes a value, converts its magnitude to BCD and queues the digits.
`default_nettype none
module sdi_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [sdi_pkg::WORD_W-1:0]    req_value,
   input  wire                          req_push,
   output logic                         req_full,
   output sdi_pkg::sdi_entry_type       q_data,
   output logic                         q_push,
   input  wire                          q_full
);
   import sdi_pkg::*;

   localparam int STEP_W = $clog2(CONV_STEPS);

   typedef enum logic [1:0] {IDLE, CONV, HOLD} state_type;

   state_type           state_ff, state_in;
   logic [WORD_W-1:0]   mag_ff, mag_in;
   logic [DIG_BITS-1:0] bcd_ff, bcd_in;
   logic                neg_ff, neg_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]    ndig;

   assign req_full = (state_ff != IDLE);
   assign q_push   = (state_ff == HOLD) && !q_full;

   always_comb begin
      ndig = 4'd1;
      for (int d = 1; d < NUM_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] != 4'd0) begin
            ndig = CNT_W'(d + 1);
         end
      end
   end

   assign q_data.neg    = neg_ff;
   assign q_data.digits = bcd_ff;
   assign q_data.ndig   = ndig;
   assign q_data.wid    = ndig + {3'b000, neg_ff};

   always_comb begin
      logic [WORD_W-1:0]   mag_v;
      logic [DIG_BITS-1:0] bcd_v;
      mag_v    = mag_ff;
      bcd_v    = bcd_ff;
      state_in = state_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_push) begin
               neg_in   = req_value[WORD_W-1];
               mag_v    = req_value[WORD_W-1] ? (WORD_W'(0) - req_value) : req_value;
               bcd_v    = '0;
               step_in  = '0;
               state_in = CONV;
            end
         end
         CONV: begin
            for (int s = 0; s < BITS_PER_STEP; s++) begin
               for (int d = 0; d < NUM_DIGITS; d++) begin
                  if (bcd_v[4*d +: 4] >= 4'd5) begin
                     bcd_v[4*d +: 4] = bcd_v[4*d +: 4] + 4'd3;
                  end
               end
               bcd_v = {bcd_v[DIG_BITS-2:0], mag_v[WORD_W-1]};
               mag_v = {mag_v[WORD_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CONV_STEPS - 1)) begin
               state_in = HOLD;
            end
         end
         HOLD: begin
            if (!q_full) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      mag_in = mag_v;
      bcd_in = bcd_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
   end
endmodule
`default_nettype wire

@@ sv/sdi_queue.sv @@
// Short queue of converted digit sets between front and back ends.
`default_nettype none
module sdi_queue #(
   parameter int DEPTH = sdi_pkg::QUEUE_DEPTH
) (
   input  wire                     clock,
   input  wire                     reset,
   input  sdi_pkg::sdi_entry_type  wr_data,
   input  wire                     push,
   output logic                    full,
   output sdi_pkg::sdi_entry_type  rd_data,
   input  wire                     pop,
   output logic                    empty
);
   import sdi_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_Q = $clog2(DEPTH + 1);

   sdi_entry_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_Q-1:0] count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_Q'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end
endmodule
`default_nettype wire

@@ sv/sdi_back.sv @@
// Back end: emits the characters of one queued number that fit the limit, then its terminator word.
`default_nettype none
module sdi_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [sdi_pkg::LIMIT_W-1:0]   limit,
   input  sdi_pkg::sdi_entry_type       q_data,
   input  wire                          q_empty,
   output logic                         q_pop,
   output logic [sdi_pkg::CHAR_W-1:0]   rsp_character,
   output logic                         rsp_last,
   output logic [sdi_pkg::CNT_W-1:0]    rsp_width,
   output logic                         rsp_empty,
   input  wire                          rsp_pop
);
   import sdi_pkg::*;

   typedef enum logic {IDLE, RUN} state_type;

   state_type        state_ff;
   sdi_entry_type    ent_ff;
   logic [CNT_W-1:0] pos_ff;
   logic             valid_ff;
   logic [CHAR_W-1:0] char_ff;
   logic             last_ff;
   logic [CNT_W-1:0] width_ff;

   logic [LIMIT_W-1:0] allowed;
   logic [CNT_W-1:0]   emit;
   logic [CNT_W-1:0]   di;
   logic [3:0]         digit;
   logic [CHAR_W-1:0]  text_char;
   logic               slot_free;

   assign q_pop     = (state_ff == IDLE) && !q_empty;
   assign slot_free = !valid_ff || rsp_pop;

   assign allowed = (limit == '0) ? '0 : limit - 1'b1;
   assign emit    = (allowed >= {3'b000, ent_ff.wid}) ? ent_ff.wid : allowed[CNT_W-1:0];
   assign di      = ent_ff.ndig - 4'd1 + {3'b000, ent_ff.neg} - pos_ff;

   always_comb begin
      digit = 4'd0;
      if (di < CNT_W'(NUM_DIGITS)) begin
         digit = ent_ff.digits[{di, 2'b00} +: 4];
      end
      text_char = (ent_ff.neg && pos_ff == '0) ? CH_MINUS : (CH_ZERO + {4'b0000, digit});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && state_ff != RUN) begin
            valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (!q_empty) begin
                  ent_ff   <= q_data;
                  pos_ff   <= '0;
                  state_ff <= RUN;
               end
            end
            RUN: begin
               if (slot_free) begin
                  valid_ff <= 1'b1;
                  if (pos_ff < emit) begin
                     char_ff  <= text_char;
                     last_ff  <= 1'b0;
                     width_ff <= '0;
                     pos_ff   <= pos_ff + 1'b1;
                  end else begin
                     char_ff  <= CH_NUL;
                     last_ff  <= 1'b1;
                     width_ff <= ent_ff.wid;
                     state_ff <= IDLE;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_width     = width_ff;
   assign rsp_empty     = !valid_ff;
endmodule
`default_nettype wire

@@ sv/signed_int_to_decimal_ascii.sv @@
// Top level: signed 32-bit integer to decimal ASCII text, one character per word.
//
//   channel  direction  handshake           payload
//   req      in         req_push/req_full   req_value[31:0] signed
//   rsp      out        rsp_pop/rsp_empty   rsp_character[7:0], rsp_last, rsp_width[3:0]
//   csr      in         csr_valid/csr_ready csr_buffer_limit[6:0]
//
// Front end accepts a number, converts its magnitude to BCD at 4 bits a cycle and
// hands the digits to the queue; it takes no new number until they are queued.
// Back end loads a number from the queue, then sends one word a cycle while the
// output slot is free (empty or being popped), up to 12 words per number.
// Reset sets buffer_limit to 12 and empties queue and output; the output register
// lets the front run on while rsp stalls, until the queue fills.
`default_nettype none
module signed_int_to_decimal_ascii #(
   parameter int QUEUE_DEPTH = sdi_pkg::QUEUE_DEPTH
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [sdi_pkg::WORD_W-1:0]    req_value,
   input  wire                          req_push,
   output logic                         req_full,
   output logic [sdi_pkg::CHAR_W-1:0]   rsp_character,
   output logic                         rsp_last,
   output logic [sdi_pkg::CNT_W-1:0]    rsp_width,
   output logic                         rsp_empty,
   input  wire                          rsp_pop,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [sdi_pkg::LIMIT_W-1:0]   csr_buffer_limit
);
   import sdi_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   sdi_entry_type      wr_entry, rd_entry;
   logic               q_push, q_full, q_pop, q_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_buffer_limit;
      end
   end

   sdi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_value),
      .req_push  (req_push),
      .req_full  (req_full),
      .q_data    (wr_entry),
      .q_push    (q_push),
      .q_full    (q_full)
   );

   sdi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_data (wr_entry),
      .push    (q_push),
      .full    (q_full),
      .rd_data (rd_entry),
      .pop     (q_pop),
      .empty   (q_empty)
   );

   sdi_back u_back (
      .clock         (clock),
      .reset         (reset),
      .limit         (limit_ff),
      .q_data        (rd_entry),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .rsp_width     (rsp_width),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop)
   );

`ifndef SYNTHESIS
   a_term_word: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last) |-> (rsp_character == CH_NUL && rsp_width != '0))
      else $error("terminator word malformed");

   a_char_word: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last) |-> (rsp_width == '0))
      else $error("width set on character word");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last) |->
         (rsp_character == CH_MINUS ||
          (rsp_character >= CH_ZERO && rsp_character <= CH_ZERO + 8'd9)))
      else $error("character word not a digit or minus");
`endif
endmodule
`default_nettype wire

@@ tb/signed_int_to_decimal_ascii_tb.sv @@
// Self-checking testbench for the signed integer to decimal ASCII text converter.
module signed_int_to_decimal_ascii_tb;
   import sdi_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
      logic [CNT_W-1:0]  width;
   } text_word_type;

   class digit_text_tracker;
      text_word_type expected_words[$];
      int unsigned   buffer_limit;
      int            fails;

      function new();
         buffer_limit = LIMIT_RESET;
         fails        = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // spell out one accepted value as the words it should produce
      function void note_value(logic [WORD_W-1:0] value);
         logic              neg;
         logic [WORD_W-1:0] mag;
         logic [CHAR_W-1:0] rev[NUM_DIGITS];
         logic [CHAR_W-1:0] text[NUM_DIGITS+1];
         int                ndig;
         int                wid;
         int                allowed;
         int                emit;
         text_word_type     w;
         neg  = value[WORD_W-1];
         mag  = neg ? (~value + 1'b1) : value;
         ndig = 0;
         wid  = 0;
         do begin
            rev[ndig] = CH_ZERO + CHAR_W'(mag % 10);
            ndig++;
            mag = mag / 10;
         end while (mag != 0 && ndig < NUM_DIGITS);
         if (neg) begin
            text[wid] = CH_MINUS;
            wid++;
         end
         for (int i = ndig - 1; i >= 0; i--) begin
            text[wid] = rev[i];
            wid++;
         end
         allowed = (buffer_limit == 0) ? 0 : int'(buffer_limit) - 1;
         emit    = (wid < allowed) ? wid : allowed;
         for (int k = 0; k < emit; k++) begin
            w.character = text[k];
            w.last      = 1'b0;
            w.width     = '0;
            expected_words.push_back(w);
         end
         w.character = CH_NUL;
         w.last      = 1'b1;
         w.width     = CNT_W'(wid);
         expected_words.push_back(w);
      endfunction

      function void check_word(logic [CHAR_W-1:0] ch, logic last, logic [CNT_W-1:0] wid);
         text_word_type exp_w;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word char=%h last=%b width=%0d", $time, ch, last, wid);
            fails++;
            return;
         end
         exp_w = expected_words.pop_front();
         if (ch !== exp_w.character) begin
            $display("%0t: character mismatch expected %h actual %h",
                     $time, exp_w.character, ch);
            fails++;
         end
         if (last !== exp_w.last) begin
            $display("%0t: last mismatch expected %b actual %b", $time, exp_w.last, last);
            fails++;
         end
         if (wid !== exp_w.width) begin
            $display("%0t: width mismatch expected %0d actual %0d", $time, exp_w.width, wid);
            fails++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset            = 1'b1;
   logic [WORD_W-1:0]   req_value        = '0;
   logic                req_push         = 1'b0;
   logic                req_full;
   logic [CHAR_W-1:0]   rsp_character;
   logic                rsp_last;
   logic [CNT_W-1:0]    rsp_width;
   logic                rsp_empty;
   logic                rsp_pop          = 1'b0;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   logic [LIMIT_W-1:0]  csr_buffer_limit = '0;

   int                  send_idle = 0;
   int                  recv_idle = 0;
   digit_text_tracker   tracker   = new();

   signed_int_to_decimal_ascii i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .req_push         (req_push),
      .req_full         (req_full),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .rsp_width        (rsp_width),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_buffer_limit (csr_buffer_limit)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         tracker.check_word(rsp_character, rsp_last, rsp_width);
      end
   end

   task automatic push_value(logic [WORD_W-1:0] value);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push  <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_full);
      tracker.note_value(value);
   endtask

   task automatic drain_text();
      req_push <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] lim);
      drain_text();
      csr_valid        <= 1'b1;
      csr_buffer_limit <= lim;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.buffer_limit = lim;
   endtask

   function automatic logic [WORD_W-1:0] pick_value();
      logic [WORD_W-1:0] v;
      logic [WORD_W-1:0] p;
      int                k;
      p = 1;
      k = $urandom_range(NUM_DIGITS - 1);
      for (int i = 0; i < k; i++) p = p * 10;
      case ($urandom_range(5))
         0, 1: v = $urandom;
         2: v = $urandom % (p * 10 > p ? p * 10 : p);
         3: v = p - $urandom_range(1);
         4: v = p + $urandom_range(1);
         default: begin
            case ($urandom_range(4))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'h8000_0001;
               3: v = 32'hFFFF_FFFF;
               default: v = '0;
            endcase
         end
      endcase
      if ($urandom_range(1)) v = ~v + 1'b1;
      return v;
   endfunction

   initial begin
      logic [WORD_W-1:0] directed[$];
      int                limits[12];
      int                idx;
      directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                   32'hC465_3601, 32'd123456789};
      limits   = '{12, 0, 64, 5, 127, 1, 11, 2, 10, 63, 0, 7};
      limits[3] = $urandom_range(127);
      limits[9] = $urandom_range(127);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle = 38;
      recv_idle = 73;
      foreach (directed[i]) push_value(directed[i]);

      // zero, one, two and the top limit on the hardest values
      foreach (limits[i]) begin
         if (i < 4) begin
            write_limit((i == 3) ? 7'd127 : LIMIT_W'(i));
            push_value(32'h8000_0000);
            push_value(32'd0);
            push_value(32'h7FFF_FFFF);
         end
      end

      idx = 0;
      for (int mode = 0; mode < 3; mode++) begin
         send_idle = (mode == 0) ? 38 : (mode == 1) ? 73 : 0;
         recv_idle = (mode == 0) ? 73 : (mode == 1) ? 38 : 0;
         for (int s = 0; s < 4; s++) begin
            write_limit(LIMIT_W'(limits[idx]));
            idx++;
            repeat (40) push_value(pick_value());
         end
      end

      drain_text();
      repeat (30) @(posedge clock);
      if (tracker.fails == 0 && tracker.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
